// ===== sv/gn2d_pkg.sv =====
// gn2d_pkg: shared constants, types and functions for the 2d gradient noise pipeline
// no dependencies
`timescale 1ns / 1ps
package gn2d_pkg;

    localparam int ANGLE_BITS = 10;
    localparam int FRAC_BITS  = 8;
    localparam int COORD_W    = 24;
    localparam int CELL_W     = COORD_W - FRAC_BITS;
    localparam int DOT_W      = 32;
    localparam int FADE_W     = 18;
    localparam int TBL_N      = 1 << ANGLE_BITS;

    localparam logic [31:0] K_SEED_A = 32'd374761393;
    localparam logic [31:0] K_SEED_B = 32'd668265263;
    localparam logic [31:0] K_MIX_1  = 32'd3284157443;
    localparam logic [31:0] K_MIX_2  = 32'd1911520717;
    localparam logic [31:0] K_MIX_3  = 32'd2048419325;

    localparam logic [63:0] SIN_A1 = 64'd1686629713;
    localparam logic [63:0] SIN_A3 = 64'd693598669;
    localparam logic [63:0] SIN_A5 = 64'd85569306;
    localparam logic [63:0] SIN_A7 = 64'd5026994;
    localparam logic [63:0] SIN_A9 = 64'd172271;

    typedef logic signed [15:0] grad_t;
    typedef logic signed [DOT_W-1:0] dot_t;

    // elaboration-time sine for table construction
    function automatic logic signed [15:0] quarter_sin(input logic [63:0] z);
        logic [63:0] z2;
        logic [63:0] t;
        logic [63:0] s;
        z2 = (z * z) << 2;
        t  = SIN_A7 - ((SIN_A9 * z2) >> 30);
        t  = SIN_A5 - ((t * z2) >> 30);
        t  = SIN_A3 - ((t * z2) >> 30);
        t  = SIN_A1 - ((t * z2) >> 30);
        s  = (t * z) >> 14;
        s  = (s + 64'd32768) >> 16;
        return 16'(s);
    endfunction

    function automatic grad_t table_sin(input logic [15:0] p);
        logic [15:0] v;
        logic [63:0] r;
        r = {50'd0, p[13:0]};
        v = p[14] ? quarter_sin(64'd16384 - r) : quarter_sin(r);
        return p[15] ? -$signed(v) : $signed(v);
    endfunction

    typedef grad_t grad_tbl_t [TBL_N];

    function automatic grad_tbl_t build_sin();
        grad_tbl_t tb;
        for (int i = 0; i < TBL_N; i++)
        begin
            tb[i] = table_sin(16'(i << (16 - ANGLE_BITS)));
        end
        return tb;
    endfunction

    localparam grad_tbl_t SIN_TBL = build_sin();

endpackage

// ===== sv/gn2d_if.sv =====
// gn2d_if: valid/ready channel interfaces for input and result items
// depends on gn2d_pkg
`timescale 1ns / 1ps
interface gn2d_in_if;
    logic valid;
    logic ready;
    logic signed [gn2d_pkg::COORD_W-1:0] x_coord;
    logic signed [gn2d_pkg::COORD_W-1:0] y_coord;
    modport source (output valid, output x_coord, output y_coord, input ready);
    modport sink (input valid, input x_coord, input y_coord, output ready);
endinterface

interface gn2d_out_if;
    logic valid;
    logic ready;
    logic signed [15:0] noise_value;
    modport source (output valid, output noise_value, input ready);
    modport sink (input valid, input noise_value, output ready);
endinterface

// ===== sv/gradient_noise_2d_sample.sv =====
// gradient_noise_2d_sample: top level, one 2d gradient noise sample per item
// depends on gn2d_pkg, gn2d_if, gn2d_fade, gn2d_corner, gn2d_blend
// pipeline: 13 register stages from input accept to result valid
// throughput: one item per cycle while the output is not stalled, set by the fully pipelined hash multipliers
// stall: whole pipeline freezes only when the output holds an untaken item
// reset: async active low clears valid bits and the seed to zero
`timescale 1ns / 1ps
module gradient_noise_2d_sample
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    gn2d_in_if.sink     in_ch,
    gn2d_out_if.source  out_ch
);
    localparam int LAT = 13;
    localparam int FB  = gn2d_pkg::FRAC_BITS;
    localparam int CW  = gn2d_pkg::CELL_W;

    logic [31:0] seed_a_reg, seed_b_reg;
    logic [LAT-1:0] vld_reg;
    logic en;

    // pipeline advances unless the last stage holds an item not taken
    assign en = !vld_reg[LAT-1] || out_ch.ready;
    assign in_ch.ready = en;
    assign out_ch.valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_a_reg <= '0;
            seed_b_reg <= '0;
            vld_reg    <= '0;
        end
        else
        begin
            // seed kept as its two products, registered on the write
            if (cfg_we)
            begin
                seed_a_reg <= cfg_wdata * gn2d_pkg::K_SEED_A;
                seed_b_reg <= cfg_wdata * gn2d_pkg::K_SEED_B;
            end
            if (en)
                vld_reg <= {vld_reg[LAT-2:0], in_ch.valid};
        end
    end

    // stage 0: split the point into cell and fraction
    logic [31:0] x0_reg, y0_reg;
    logic [FB-1:0] fx_reg, fy_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg <= 32'($signed(in_ch.x_coord[gn2d_pkg::COORD_W-1:FB]));
            y0_reg <= 32'($signed(in_ch.y_coord[gn2d_pkg::COORD_W-1:FB]));
            fx_reg <= in_ch.x_coord[FB-1:0];
            fy_reg <= in_ch.y_coord[FB-1:0];
        end
    end

    // corner offsets, frac minus one where needed
    logic signed [FB+1:0] dx0, dy0, dx1, dy1;
    assign dx0 = $signed({2'b00, fx_reg});
    assign dy0 = $signed({2'b00, fy_reg});
    assign dx1 = dx0 - (FB+2)'(1 << FB);
    assign dy1 = dy0 - (FB+2)'(1 << FB);

    gn2d_pkg::dot_t n0, n1, n2, n3;

    gn2d_corner u_c0 (.clk, .en, .ix(x0_reg), .iy(y0_reg), .seed_a(seed_a_reg),
        .seed_b(seed_b_reg), .dx(dx0), .dy(dy0), .dot(n0));
    gn2d_corner u_c1 (.clk, .en, .ix(x0_reg + 32'd1), .iy(y0_reg), .seed_a(seed_a_reg),
        .seed_b(seed_b_reg), .dx(dx1), .dy(dy0), .dot(n1));
    gn2d_corner u_c2 (.clk, .en, .ix(x0_reg), .iy(y0_reg + 32'd1), .seed_a(seed_a_reg),
        .seed_b(seed_b_reg), .dx(dx0), .dy(dy1), .dot(n2));
    gn2d_corner u_c3 (.clk, .en, .ix(x0_reg + 32'd1), .iy(y0_reg + 32'd1),
        .seed_a(seed_a_reg), .seed_b(seed_b_reg), .dx(dx1), .dy(dy1), .dot(n3));

    // fade is shorter than the corner pipeline, so the fades pass through sx1_reg and sx2_reg to line up with the dots
    logic [gn2d_pkg::FADE_W-1:0] sx, sy, sx1_reg, sy1_reg, sx2_reg, sy2_reg;
    gn2d_fade u_fx (.clk, .en, .frac(fx_reg), .fade(sx));
    gn2d_fade u_fy (.clk, .en, .frac(fy_reg), .fade(sy));
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx1_reg <= sx;
            sy1_reg <= sy;
            sx2_reg <= sx1_reg;
            sy2_reg <= sy1_reg;
        end
    end

    // blend: 6 stages to the saturated result
    gn2d_blend u_bl (.clk, .en, .n0, .n1, .n2, .n3, .sx(sx2_reg), .sy(sy2_reg),
        .noise(out_ch.noise_value));
endmodule

// ===== sv/gn2d_fade.sv =====
// gn2d_fade: pipelined quintic fade of a lattice fraction, four stages, Q16 result
// depends on gn2d_pkg
`timescale 1ns / 1ps
module gn2d_fade
(
    input  logic                             clk,
    input  logic                             en,
    input  logic [gn2d_pkg::FRAC_BITS-1:0]   frac,
    output logic [gn2d_pkg::FADE_W-1:0]      fade
);
    localparam int FADE_W_L = gn2d_pkg::FADE_W;
    logic [16:0] t_reg;
    logic [33:0] t2_reg;
    logic [16:0] t1_reg;
    logic [16:0] t3_reg;
    logic signed [20:0] inner_reg;
    logic [16:0] t3_next;
    logic signed [20:0] inner_next;
    logic [FADE_W_L-1:0] fade_reg;

    always_comb
    begin
        t3_next    = 17'(({17'd0, t2_reg} * {34'd0, t1_reg}) >> 32);
        inner_next = 21'(((38'sd6 * $signed({4'b0, t2_reg})) >>> 16)
                     - 38'sd15 * $signed({21'd0, t1_reg}) + 38'sd655360);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg     <= 17'({frac, {(16 - gn2d_pkg::FRAC_BITS){1'b0}}});
            t2_reg    <= t_reg * t_reg;
            t1_reg    <= t_reg;
            t3_reg    <= t3_next;
            inner_reg <= inner_next;
            fade_reg  <= FADE_W_L'((40'($signed({1'b0, t3_reg})) * 40'(inner_reg)) >>> 16);
        end
    end

    assign fade = fade_reg;
endmodule

// ===== sv/gn2d_corner.sv =====
// gn2d_corner: pipelined corner hash, gradient lookup and dot product, six stages
// depends on gn2d_pkg
`timescale 1ns / 1ps
module gn2d_corner
(
    input  logic                                clk,
    input  logic                                en,
    input  logic [31:0]                         ix,
    input  logic [31:0]                         iy,
    input  logic [31:0]                         seed_a,
    input  logic [31:0]                         seed_b,
    input  logic signed [gn2d_pkg::FRAC_BITS+1:0] dx,
    input  logic signed [gn2d_pkg::FRAC_BITS+1:0] dy,
    output gn2d_pkg::dot_t                      dot
);
    localparam int DW = gn2d_pkg::FRAC_BITS + 2;
    localparam int AW = gn2d_pkg::ANGLE_BITS;
    localparam int OW = gn2d_pkg::DOT_W;
    localparam logic [AW-1:0] QTR = AW'(1 << (AW - 2));
    logic [31:0] a1_reg, b1_reg, a2_reg, b2_reg, b3_reg, a3_reg, a2d_reg;
    logic signed [DW-1:0] dx_reg [5], dy_reg [5];
    logic [31:0] b2_next, a3_next;
    logic [AW-1:0] idx;
    gn2d_pkg::grad_t gx_reg, gy_reg;
    gn2d_pkg::dot_t dot_reg;

    assign b2_next = b2_reg ^ {a2_reg[15:0], a2_reg[31:16]};
    assign a3_next = a2d_reg ^ {b3_reg[15:0], b3_reg[31:16]};
    assign idx = a3_reg[31 -: AW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg  <= ix + seed_a;
            b1_reg  <= iy + seed_b;
            a2_reg  <= a1_reg * gn2d_pkg::K_MIX_1;
            b2_reg  <= b1_reg;
            b3_reg  <= b2_next * gn2d_pkg::K_MIX_2;
            a2d_reg <= a2_reg;
            a3_reg  <= a3_next * gn2d_pkg::K_MIX_3;
            gx_reg  <= gn2d_pkg::SIN_TBL[idx + QTR];
            gy_reg  <= gn2d_pkg::SIN_TBL[idx];
            dot_reg <= OW'(gx_reg) * OW'(dx_reg[4]) + OW'(gy_reg) * OW'(dy_reg[4]);
            dx_reg[0] <= dx;
            dy_reg[0] <= dy;
            for (int i = 1; i < 5; i++)
            begin
                dx_reg[i] <= dx_reg[i-1];
                dy_reg[i] <= dy_reg[i-1];
            end
        end
    end

    assign dot = dot_reg;
endmodule

// ===== sv/gn2d_blend.sv =====
// gn2d_blend: pipelined bilinear blend of four corner dots, final rounding and saturation to 16 bits
// depends on gn2d_pkg
`timescale 1ns / 1ps
module gn2d_blend
(
    input  logic                           clk,
    input  logic                           en,
    input  gn2d_pkg::dot_t                 n0,
    input  gn2d_pkg::dot_t                 n1,
    input  gn2d_pkg::dot_t                 n2,
    input  gn2d_pkg::dot_t                 n3,
    input  logic [gn2d_pkg::FADE_W-1:0]    sx,
    input  logic [gn2d_pkg::FADE_W-1:0]    sy,
    output logic signed [15:0]             noise
);
    localparam int DW = gn2d_pkg::DOT_W;
    localparam int FB = gn2d_pkg::FRAC_BITS;
    logic signed [DW-1:0] a0_reg, a2_reg, d0_reg, d2_reg, u_reg, w_reg, e_reg;
    logic signed [DW-1:0] u0_reg, w0_reg, u1_reg;
    logic [gn2d_pkg::FADE_W-1:0] sx1_reg, sy1_reg, sy2_reg, sy3_reg, sy4_reg;
    logic signed [DW+19:0] p0_reg, p2_reg;
    logic signed [DW-1:0] v_reg;
    logic signed [DW-1:0] r;
    logic signed [15:0] out_reg;

    assign r = (v_reg + DW'(1 << (FB - 2))) >>> (FB - 1);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a0_reg  <= n0;
            a2_reg  <= n2;
            d0_reg  <= n1 - n0;
            d2_reg  <= n3 - n2;
            sx1_reg <= sx;
            sy1_reg <= sy;
            p0_reg  <= $signed({1'b0, sx1_reg}) * d0_reg;
            p2_reg  <= $signed({1'b0, sx1_reg}) * d2_reg;
            u0_reg  <= a0_reg;
            w0_reg  <= a2_reg;
            sy2_reg <= sy1_reg;
            u_reg   <= u0_reg + DW'(p0_reg >>> 16);
            w_reg   <= w0_reg + DW'(p2_reg >>> 16);
            sy3_reg <= sy2_reg;
            e_reg   <= w_reg - u_reg;
            u1_reg  <= u_reg;
            sy4_reg <= sy3_reg;
            v_reg   <= u1_reg + DW'(((DW+20)'($signed({1'b0, sy4_reg}))
                       * (DW+20)'(e_reg)) >>> 16);
            if (r > 32767)
                out_reg <= 16'sd32767;
            else if (r < -32768)
                out_reg <= -16'sd32768;
            else
                out_reg <= 16'(r);
        end
    end

    assign noise = out_reg;
endmodule

// ===== test/testbench.sv =====
// testbench: self-checking bench for gradient_noise_2d_sample
// depends on gn2d_pkg, gn2d_if and the gradient_noise_2d_sample rtl
`timescale 1ns / 1ps
module testbench;

    typedef logic signed [gn2d_pkg::COORD_W-1:0] coord_t;
    typedef logic signed [15:0] noise_t;

    // one row of the directed stimulus table
    typedef struct {
        coord_t x;
        coord_t y;
        bit     known;   // expected value typed in below
        noise_t value;
    } sample_row_t;

    localparam int N_ROWS = 16;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [31:0] cfg_wdata;

    gn2d_in_if  in_ch ();
    gn2d_out_if out_ch ();

    gradient_noise_2d_sample i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    // expected noise values, oldest first
    noise_t pending_noise[$];
    logic [31:0] seed_copy;
    int errors;
    int ready_pct;     // chance in percent that the sink takes an item
    int long_stall;    // cycles left in a long sink stall
    bit no_gaps;       // stretch with back-to-back items
    sample_row_t rows[N_ROWS];

    // sine of a quarter-turn fraction in Q14, odd polynomial with floored products
    function automatic longint quarter_wave(input logic [63:0] z);
        logic [63:0] z2;
        logic [63:0] acc;
        logic [63:0] s;
        z2  = (z * z) << 2;
        acc = 64'd5026994 - ((64'd172271 * z2) >> 30);
        acc = 64'd85569306 - ((acc * z2) >> 30);
        acc = 64'd693598669 - ((acc * z2) >> 30);
        acc = 64'd1686629713 - ((acc * z2) >> 30);
        s   = (acc * z) >> 14;
        return longint'((s + 64'd32768) >> 16);
    endfunction

    function automatic longint full_sin(input logic [15:0] phase);
        longint v;
        v = phase[14] ? quarter_wave(64'd16384 - phase[13:0]) : quarter_wave(phase[13:0]);
        return phase[15] ? -v : v;
    endfunction

    function automatic logic [31:0] mix_corner(input logic [31:0] cx, input logic [31:0] cy,
                                               input logic [31:0] seed);
        logic [31:0] a;
        logic [31:0] b;
        a = cx + seed * gn2d_pkg::K_SEED_A;
        b = cy + seed * gn2d_pkg::K_SEED_B;
        a = a * gn2d_pkg::K_MIX_1;
        b = b ^ {a[15:0], a[31:16]};
        b = b * gn2d_pkg::K_MIX_2;
        a = a ^ {b[15:0], b[31:16]};
        return a * gn2d_pkg::K_MIX_3;
    endfunction

    function automatic longint gradient_dot(input logic [31:0] cx, input logic [31:0] cy,
                                            input logic [31:0] seed,
                                            input longint dx, input longint dy);
        logic [31:0] h;
        logic [15:0] phase;
        h = mix_corner(cx, cy, seed);
        phase = 16'(h[31 -: gn2d_pkg::ANGLE_BITS]) << (16 - gn2d_pkg::ANGLE_BITS);
        return full_sin(phase + 16'd16384) * dx + full_sin(phase) * dy;
    endfunction

    // quintic fade in Q16
    function automatic longint fade_q16(input longint frac);
        longint t;
        longint t3;
        longint inner;
        t     = frac << (16 - gn2d_pkg::FRAC_BITS);
        t3    = (t * t * t) >>> 32;
        inner = ((6 * t * t) >>> 16) - 15 * t + 10 * 65536;
        return (t3 * inner) >>> 16;
    endfunction

    function automatic longint lerp_q16(input longint a, input longint b, input longint f);
        return a + ((f * (b - a)) >>> 16);
    endfunction

    function automatic noise_t noise_at(input coord_t x, input coord_t y,
                                        input logic [31:0] seed);
        longint one;
        longint px;
        longint py;
        longint cx;
        longint cy;
        longint fx;
        longint fy;
        longint sx;
        longint sy;
        longint v;
        logic [31:0] x0;
        logic [31:0] y0;
        one = longint'(1) << gn2d_pkg::FRAC_BITS;
        px  = longint'(x);
        py  = longint'(y);
        cx  = px >>> gn2d_pkg::FRAC_BITS;
        cy  = py >>> gn2d_pkg::FRAC_BITS;
        fx  = px - cx * one;
        fy  = py - cy * one;
        x0  = cx[31:0];
        y0  = cy[31:0];
        sx  = fade_q16(fx);
        sy  = fade_q16(fy);
        // the +1 corners wrap mod 2^32
        v = lerp_q16(lerp_q16(gradient_dot(x0, y0, seed, fx, fy),
                              gradient_dot(x0 + 1, y0, seed, fx - one, fy), sx),
                     lerp_q16(gradient_dot(x0, y0 + 1, seed, fx, fy - one),
                              gradient_dot(x0 + 1, y0 + 1, seed, fx - one, fy - one), sx),
                     sy);
        v = (v + (longint'(1) << (gn2d_pkg::FRAC_BITS - 2))) >>> (gn2d_pkg::FRAC_BITS - 1);
        if (v > 32767)
        begin
            v = 32767;
        end
        if (v < -32768)
        begin
            v = -32768;
        end
        return noise_t'(v);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // sink side: random stalls, mostly short, now and then a long one
    always @(posedge clk)
    begin
        if (long_stall > 0)
        begin
            long_stall <= long_stall - 1;
            out_ch.ready <= 1'b0;
        end
        else if ($urandom_range(0, 299) == 0)
        begin
            long_stall <= $urandom_range(10, 60);
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= ($urandom_range(0, 99) < ready_pct);
        end
    end

    // result checker: every taken item is compared with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_noise.size() == 0)
            begin
                $display("%0t: noise_value %0d arrived with nothing expected",
                         $realtime, out_ch.noise_value);
                errors++;
            end
            else
            begin
                noise_t want;
                want = pending_noise.pop_front();
                if (out_ch.noise_value !== want)
                begin
                    $display("%0t: noise_value expected %0d actual %0d",
                             $realtime, want, out_ch.noise_value);
                    errors++;
                end
            end
        end
    end

    // sender gap: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        if (no_gaps)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // drive one item, wait for it to be taken, then record the prediction
    task automatic send_sample(input coord_t x, input coord_t y,
                               input bit known, input noise_t value);
        int gap;
        in_ch.valid   <= 1'b1;
        in_ch.x_coord <= x;
        in_ch.y_coord <= y;
        do
        begin
            @(posedge clk);
        end
        while (!in_ch.ready);
        pending_noise.push_back(known ? value : noise_at(x, y, seed_copy));
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // seed writes only while the pipeline is empty
    task automatic write_seed(input logic [31:0] seed);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_noise.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= seed;
        @(posedge clk);
        cfg_we    <= 1'b0;
        seed_copy = seed;
    endtask

    // random point: full range, near the origin, or near the extremes
    task automatic send_random();
        coord_t x;
        coord_t y;
        int kind;
        kind = $urandom_range(0, 9);
        x = coord_t'($urandom());
        y = coord_t'($urandom());
        if (kind < 3)
        begin
            x = coord_t'($urandom_range(0, 2047)) - coord_t'(1024);
            y = coord_t'($urandom_range(0, 2047)) - coord_t'(1024);
        end
        else if (kind == 3)
        begin
            // cells at both ends of the range, fraction kept random
            x = {($urandom_range(0, 1) ? 16'h7FFF : 16'h8000), x[7:0]};
            y = {($urandom_range(0, 1) ? 16'h7FFF : 16'h8000), y[7:0]};
        end
        send_sample(x, y, 1'b0, '0);
    endtask

    initial
    begin
        int limit;
        logic [31:0] seeds[5];

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        in_ch.valid  = 1'b0;
        in_ch.x_coord = '0;
        in_ch.y_coord = '0;
        out_ch.ready = 1'b0;
        seed_copy    = '0;
        errors       = 0;
        ready_pct    = 80;
        long_stall   = 0;
        no_gaps      = 1'b0;

        // lattice points give zero offsets, so the noise there is zero
        rows = '{
            '{24'sh000000, 24'sh000000, 1'b1, 16'sd0},
            '{24'sh7FFF00, 24'sh7FFF00, 1'b1, 16'sd0},
            '{24'sh800000, 24'sh800000, 1'b1, 16'sd0},
            '{24'sh7FFF00, 24'sh800000, 1'b1, 16'sd0},
            '{24'shFFFF00, 24'sh000100, 1'b1, 16'sd0},
            '{24'sh7FFFFF, 24'sh7FFFFF, 1'b0, 16'sd0},
            '{24'sh800001, 24'sh7FFFFF, 1'b0, 16'sd0},
            '{24'shFFFFFF, 24'shFFFFFF, 1'b0, 16'sd0},
            '{24'sh000001, 24'sh000001, 1'b0, 16'sd0},
            '{24'sh000080, 24'sh000080, 1'b0, 16'sd0},
            '{24'sh0000FF, 24'sh000000, 1'b0, 16'sd0},
            '{24'sh000000, 24'sh0000FF, 1'b0, 16'sd0},
            '{24'shFFFF80, 24'sh000040, 1'b0, 16'sd0},
            '{24'sh7FFF80, 24'sh7FFFC0, 1'b0, 16'sd0},
            '{24'sh8000C0, 24'sh800040, 1'b0, 16'sd0},
            '{24'sh5A5AA5, 24'shA5A55A, 1'b0, 16'sd0}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset seed
        foreach (rows[i])
        begin
            send_sample(rows[i].x, rows[i].y, rows[i].known, rows[i].value);
        end

        // random phases over extreme and random seeds
        seeds[0] = 32'h7FFFFFFF;
        seeds[1] = 32'h80000000;
        seeds[2] = 32'hFFFFFFFF;
        seeds[3] = $urandom();
        seeds[4] = 32'h00000000;
        foreach (seeds[k])
        begin
            write_seed(seeds[k]);
            // the middle phases stress full rate, then heavy back pressure
            no_gaps   = (k == 1);
            ready_pct = (k == 1) ? 100 : ((k == 2) ? 30 : 80);
            if (k == 2)
            begin
                foreach (rows[i])
                begin
                    send_sample(rows[i].x, rows[i].y, rows[i].known, rows[i].value);
                end
            end
            repeat (280) send_random();
        end
        in_ch.valid <= 1'b0;

        // drain, then keep clocking to catch any stray result
        limit = 0;
        while (pending_noise.size() != 0 && limit < 100000)
        begin
            @(posedge clk);
            limit++;
        end
        repeat (40) @(posedge clk);
        if (errors == 0 && pending_noise.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
sv/gn2d_pkg.sv
sv/gn2d_if.sv
sv/gn2d_fade.sv
sv/gn2d_corner.sv
sv/gn2d_blend.sv
sv/gradient_noise_2d_sample.sv
test/testbench.sv
